@@ src/tcw_pkg.sv @@
// text console writer package: cell type, operation codes, character constants
// and the hex glyph lookup used by the controller; the cell type is shared with the screen memory
// no dependencies
package tcw_pkg;

	// default screen geometry
	localparam int DEF_SCREEN_COLS = 80;
	localparam int DEF_SCREEN_ROWS = 25;

	// character and attribute constants
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h0F;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] PREFIX_ZERO = 8'h30;
	localparam logic [7:0] PREFIX_X = 8'h78;

	// put-hex emits a two-glyph prefix and eight digits
	localparam int HEX_LEN = 10;
	localparam int HEX_PREFIX_LEN = 2;
	localparam int HEX_IDX_W = 4;

	// operation codes
	typedef enum logic [1:0] {
		OP_PUT_CHAR = 2'd0,
		OP_PUT_HEX = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ = 2'd3
	} op_t;

	// one screen cell: attribute in the high byte, character in the low byte
	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] chr;
	} cell_t;

	// upper-case hex digit glyph
	function automatic logic [7:0] hex_glyph(input logic [3:0] nibble);
		logic [7:0] g;
		unique case (nibble)
			4'h0: g = 8'h30;
			4'h1: g = 8'h31;
			4'h2: g = 8'h32;
			4'h3: g = 8'h33;
			4'h4: g = 8'h34;
			4'h5: g = 8'h35;
			4'h6: g = 8'h36;
			4'h7: g = 8'h37;
			4'h8: g = 8'h38;
			4'h9: g = 8'h39;
			4'hA: g = 8'h41;
			4'hB: g = 8'h42;
			4'hC: g = 8'h43;
			4'hD: g = 8'h44;
			4'hE: g = 8'h45;
			4'hF: g = 8'h46;
			default: g = 8'h30;
		endcase
		return g;
	endfunction

endpackage

@@ src/text_console_writer_core.sv @@
// Text console writer. Accepts one command word when start is high and busy is low and
// returns one result word, marked by a one-cycle done strobe that the receiver must take.
// A put-character or put-hex writes one memory cell per glyph, a newline excepted. A scroll
// runs a copy pass through the single read port, then blanks the last row; a clear blanks
// every cell. After reset the block sweeps all SCREEN_COLS*SCREEN_ROWS cells (2000 by
// default) of the screen memory to blanks with busy high; the attribute register can be
// written over APB at any time.
// depends on tcw_pkg, tcw_ctrl, tcw_screen_mem
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLS = DEF_SCREEN_COLS,
	parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  operation,
	input  logic [7:0]  char_code,
	input  logic [31:0] hex_value,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_column,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic [6:0]  cursor_column_now,
	output logic [4:0]  cursor_row_now
);

	localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
	localparam int AW = $clog2(CELL_COUNT);

	logic [7:0]    attr_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	cell_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	cell_t         mem_rdata;
	logic          attr_sel;

	// apb register: text attribute at byte address 0
	assign pready = 1'b1;
	assign attr_sel = (paddr[2] == 1'b0);
	assign prdata = attr_sel ? {24'h000000, attr_q} : 32'h00000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && attr_sel) begin
			attr_q <= pwdata[7:0];
		end
	end

	tcw_ctrl #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS),
		.CELL_COUNT (CELL_COUNT),
		.AW         (AW)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.done             (done),
		.operation        (operation),
		.char_code        (char_code),
		.hex_value        (hex_value),
		.read_row         (read_row),
		.read_column      (read_column),
		.text_attr        (attr_q),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_re           (mem_re),
		.mem_raddr        (mem_raddr),
		.mem_rdata        (mem_rdata),
		.cell_char        (cell_char),
		.cell_attr        (cell_attr),
		.cursor_column_now(cursor_column_now),
		.cursor_row_now   (cursor_row_now)
	);

	tcw_screen_mem #(
		.DEPTH(CELL_COUNT),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

@@ src/tcw_screen_mem.sv @@
// screen store: simple dual-port synchronous memory of cells
// one write port, one read port with registered read data; uses tcw_pkg
module tcw_screen_mem
	import tcw_pkg::*;
#(
	parameter int DEPTH = DEF_SCREEN_COLS * DEF_SCREEN_ROWS,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  cell_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output cell_t         rdata
);

	cell_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/tcw_ctrl.sv @@
// text console sequencer: cursor, put-char and put-hex steps, scroll copy pass,
// blanking and clearing passes, cell read; drives the screen memory; uses tcw_pkg
module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLS = DEF_SCREEN_COLS,
	parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
	parameter int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS,
	parameter int AW = $clog2(CELL_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	input  logic [1:0]    operation,
	input  logic [7:0]    char_code,
	input  logic [31:0]   hex_value,
	input  logic [4:0]    read_row,
	input  logic [6:0]    read_column,
	input  logic [7:0]    text_attr,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output cell_t         mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  cell_t         mem_rdata,
	output logic [7:0]    cell_char,
	output logic [7:0]    cell_attr,
	output logic [6:0]    cursor_column_now,
	output logic [4:0]    cursor_row_now
);

	localparam int CW = $clog2(SCREEN_COLS);
	localparam int RW = $clog2(SCREEN_ROWS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] SCROLL_FIRST = AW'(SCREEN_COLS);
	localparam logic [AW-1:0] LAST_ROW_ADDR = AW'((SCREEN_ROWS - 1) * SCREEN_COLS);
	localparam logic [CW-1:0] COL_LAST = CW'(SCREEN_COLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_PUT    = 7'b0000100,
		ST_SCROLL = 7'b0001000,
		ST_SWAIT  = 7'b0010000,
		ST_BLANK  = 7'b0100000,
		ST_READ   = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         scan_q;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	op_t                   op_q;
	logic [7:0]            char_q;
	logic [31:0]           hex_q;
	logic [HEX_IDX_W-1:0]  idx_q;
	logic                  rd_ok_q;
	logic                  done_q;
	logic [7:0]            cell_char_q;
	logic [7:0]            cell_attr_q;
	logic                  wvalid_s1;
	logic [AW-1:0]         waddr_s1;

	op_t                   op_in;
	logic                  accept;
	logic                  rd_ok;
	logic [7:0]            glyph;
	logic                  is_newline;
	logic                  adv_row;
	logic [CW-1:0]         next_col;
	logic                  put_last;
	logic                  seq_over;
	logic [AW-1:0]         cursor_pos;

	assign op_in = op_t'(operation);
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign rd_ok = (int'(read_row) < SCREEN_ROWS) && (int'(read_column) < SCREEN_COLS);

	// glyph for the current put step
	always_comb begin
		if (op_q == OP_PUT_CHAR) begin
			glyph = char_q;
		end else if (idx_q == HEX_IDX_W'(0)) begin
			glyph = PREFIX_ZERO;
		end else if (idx_q == HEX_IDX_W'(1)) begin
			glyph = PREFIX_X;
		end else begin
			glyph = hex_glyph(hex_q[31:28]);
		end
	end

	// cursor advance
	assign is_newline = (glyph == NEWLINE_CHAR);
	assign adv_row = is_newline || (col_q == COL_LAST);
	assign next_col = adv_row ? '0 : col_q + CW'(1);
	assign put_last = (op_q == OP_PUT_CHAR) || (idx_q == HEX_IDX_W'(HEX_LEN - 1));
	assign seq_over = (op_q == OP_PUT_CHAR) || (idx_q == HEX_IDX_W'(HEX_LEN));
	assign cursor_pos = AW'(int'(row_q) * SCREEN_COLS + int'(col_q));

	// memory write port select
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = scan_q;
		mem_wdata = '{attr: text_attr, chr: BLANK_CHAR};
		if (wvalid_s1) begin
			mem_we = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == ST_INIT) begin
			mem_we = 1'b1;
			mem_wdata = '{attr: RESET_ATTR, chr: BLANK_CHAR};
		end else if (state_q == ST_BLANK) begin
			mem_we = 1'b1;
		end else if (state_q == ST_PUT) begin
			mem_we = !is_newline;
			mem_waddr = cursor_pos;
			mem_wdata = '{attr: text_attr, chr: glyph};
		end
	end

	// memory read port select
	always_comb begin
		if (state_q == ST_SCROLL) begin
			mem_re = 1'b1;
			mem_raddr = scan_q;
		end else begin
			mem_re = accept && (op_in == OP_READ) && rd_ok;
			mem_raddr = AW'(int'(read_row) * SCREEN_COLS + int'(read_column));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			scan_q <= '0;
			col_q <= '0;
			row_q <= '0;
			op_q <= OP_PUT_CHAR;
			char_q <= '0;
			hex_q <= '0;
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			done_q <= 1'b0;
			cell_char_q <= '0;
			cell_attr_q <= '0;
			wvalid_s1 <= 1'b0;
			waddr_s1 <= '0;
		end else begin
			done_q <= 1'b0;
			wvalid_s1 <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					scan_q <= scan_q + AW'(1);
					if (scan_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q <= op_in;
						char_q <= char_code;
						hex_q <= hex_value;
						idx_q <= '0;
						rd_ok_q <= rd_ok;
						cell_char_q <= '0;
						cell_attr_q <= '0;
						unique case (op_in)
							OP_PUT_CHAR, OP_PUT_HEX: state_q <= ST_PUT;
							OP_CLEAR: begin
								scan_q <= '0;
								state_q <= ST_BLANK;
							end
							OP_READ: state_q <= ST_READ;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PUT: begin
					col_q <= next_col;
					idx_q <= idx_q + HEX_IDX_W'(1);
					if (idx_q >= HEX_IDX_W'(HEX_PREFIX_LEN)) begin
						hex_q <= {hex_q[27:0], 4'h0};
					end
					if (adv_row && (row_q == ROW_LAST)) begin
						scan_q <= SCROLL_FIRST;
						state_q <= ST_SCROLL;
					end else begin
						if (adv_row) begin
							row_q <= row_q + RW'(1);
						end
						if (put_last) begin
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				// copy each row up: read one row below, write it back in the following cycle
				ST_SCROLL: begin
					wvalid_s1 <= 1'b1;
					waddr_s1 <= scan_q - SCROLL_FIRST;
					scan_q <= scan_q + AW'(1);
					if (scan_q == LAST_ADDR) begin
						state_q <= ST_SWAIT;
					end
				end
				ST_SWAIT: begin
					scan_q <= LAST_ROW_ADDR;
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					scan_q <= scan_q + AW'(1);
					if (scan_q == LAST_ADDR) begin
						if (op_q == OP_CLEAR) begin
							col_q <= '0;
							row_q <= '0;
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end else if (seq_over) begin
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_READ: begin
					cell_char_q <= rd_ok_q ? mem_rdata.chr : 8'h00;
					cell_attr_q <= rd_ok_q ? mem_rdata.attr : 8'h00;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word
	assign done = done_q;
	assign cell_char = cell_char_q;
	assign cell_attr = cell_attr_q;
	assign cursor_column_now = 7'(int'(col_q));
	assign cursor_row_now = 5'(int'(row_q));

endmodule

@@ src/tcw_checker.sv @@
// port-level checker for the text console writer, bound to the top level
// depends on text_console_writer_core port names only
module tcw_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [6:0]  cursor_column_now,
	input logic [4:0]  cursor_row_now
);

	// a result word only comes out once the command is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

	// an accepted command always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// done strobes never come back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done strobes back to back");

	// the cursor only moves while a command runs
	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && $past(!busy) && $past(arst_n) |->
		$stable(cursor_column_now) && $stable(cursor_row_now))
		else $error("cursor moved while idle");

endmodule

bind text_console_writer_core tcw_port_props u_tcw_checker (.*);

@@ sim/tcw_checker.sv @@
`timescale 1ns / 100ps
// checker for the text console writer: keeps its own screen, cursor and attribute,
// predicts the result word of every accepted command word and compares it on done
// depends on tcw_pkg
module tcw_checker
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLS = DEF_SCREEN_COLS,
	parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [1:0]  operation,
	input  logic [7:0]  char_code,
	input  logic [31:0] hex_value,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_column,
	input  logic [7:0]  cell_char,
	input  logic [7:0]  cell_attr,
	input  logic [6:0]  cursor_column_now,
	input  logic [4:0]  cursor_row_now,
	output int          error_count,
	output int          outstanding
);

	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
	localparam int ATTR_REG_IDX = 0;

	// one result word as the block should return it
	typedef struct {
		logic [7:0] chr;
		logic [7:0] attr;
		logic [6:0] col;
		logic [4:0] row;
	} console_word_t;

	cell_t screen_shadow [CELLS];
	int unsigned cur_col;
	int unsigned cur_row;
	logic [7:0] text_attr;
	console_word_t awaited_words [$];
	int fails;

	// fill a span of cells with blanks in the current attribute
	function automatic void blank_cells(int from, int upto);
		for (int i = from; i < upto; i++)
			screen_shadow[i] = {text_attr, BLANK_CHAR};
	endfunction

	// move every row up by one and blank the bottom row
	function automatic void scroll_screen();
		for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
			screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
		blank_cells((SCREEN_ROWS - 1) * SCREEN_COLS, CELLS);
		cur_row = SCREEN_ROWS - 1;
	endfunction

	// newline or glyph write at the cursor, then wrap and scroll
	function automatic void place_glyph(logic [7:0] ch);
		int unsigned pos;
		if (ch == NEWLINE_CHAR) begin
			cur_col = 0;
			cur_row++;
		end else begin
			pos = cur_row * SCREEN_COLS + cur_col;
			if (pos < CELLS)
				screen_shadow[pos] = {text_attr, ch};
			cur_col++;
		end
		if (cur_col >= SCREEN_COLS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= SCREEN_ROWS)
			scroll_screen();
	endfunction

	// upper-case ascii digit of one nibble
	function automatic logic [7:0] nibble_ascii(logic [3:0] nib);
		return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h37 + {4'h0, nib};
	endfunction

	// apply one command word to the shadow state and form its result word
	function automatic console_word_t predict_console_word(op_t op, logic [7:0] ch,
			logic [31:0] hv, logic [4:0] rr, logic [6:0] rc);
		console_word_t w;
		w.chr = '0;
		w.attr = '0;
		case (op)
			OP_PUT_CHAR: place_glyph(ch);
			OP_PUT_HEX: begin
				place_glyph(PREFIX_ZERO);
				place_glyph(PREFIX_X);
				for (int sh = 28; sh >= 0; sh -= 4)
					place_glyph(nibble_ascii(hv[sh +: 4]));
			end
			OP_CLEAR: begin
				blank_cells(0, CELLS);
				cur_col = 0;
				cur_row = 0;
			end
			OP_READ: begin
				// out-of-range coordinates read as zero
				if (rr < SCREEN_ROWS && rc < SCREEN_COLS) begin
					w.chr = screen_shadow[rr * SCREEN_COLS + rc].chr;
					w.attr = screen_shadow[rr * SCREEN_COLS + rc].attr;
				end
			end
			default: ;
		endcase
		w.col = cur_col[6:0];
		w.row = cur_row[4:0];
		return w;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen_shadow[i] = {RESET_ATTR, BLANK_CHAR};
			cur_col = 0;
			cur_row = 0;
			text_attr = RESET_ATTR;
			awaited_words.delete();
			fails = 0;
			error_count <= 0;
			outstanding <= 0;
		end else begin
			// result word leaving the block, matched first so a same-edge accept
			// cannot cover for a missing expectation
			if (done) begin
				if (awaited_words.size() == 0) begin
					$error("result word with none expected");
					fails++;
				end else begin
					want = awaited_words.pop_front();
					check_field("cell_char", want.chr, cell_char);
					check_field("cell_attr", want.attr, cell_attr);
					check_field("cursor_column_now", {1'b0, want.col}, {1'b0, cursor_column_now});
					check_field("cursor_row_now", {3'b0, want.row}, {3'b0, cursor_row_now});
				end
			end
			// attribute register access
			if (psel && penable && pready && (paddr >> 2) == ATTR_REG_IDX) begin
				if (pwrite) begin
					text_attr = pwdata[7:0];
				end else if (prdata !== {24'h0, text_attr}) begin
					$error("prdata expected %0h actual %0h", {24'h0, text_attr}, prdata);
					fails++;
				end
			end
			// command word accepted
			if (start && !busy)
				awaited_words.push_back(predict_console_word(op_t'(operation), char_code,
					hex_value, read_row, read_column));
			error_count <= fails;
			outstanding <= awaited_words.size();
		end
	end

endmodule

@@ sim/tb_text_console_writer_core.sv @@
`timescale 1ns / 100ps
// testbench top for the text console writer: drives directed and random command words
// in bursts, steps the attribute register through several values, gives the verdict
// depends on tcw_pkg, text_console_writer_core, tcw_checker
module tb_text_console_writer_core;
	import tcw_pkg::*;

	localparam int CLK_HALF = 6;
	localparam logic [2:0] ATTR_ADDR = 3'd0;
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	localparam int PHASES = 5;
	localparam int WORDS_PER_PHASE = 176;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	logic [1:0]  operation = '0;
	logic [7:0]  char_code = '0;
	logic [31:0] hex_value = '0;
	logic [4:0]  read_row = '0;
	logic [6:0]  read_column = '0;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;
	logic [6:0]  cursor_column_now;
	logic [4:0]  cursor_row_now;
	int          error_count;
	int          outstanding;

	text_console_writer_core uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .done(done),
		.operation(operation), .char_code(char_code), .hex_value(hex_value),
		.read_row(read_row), .read_column(read_column),
		.cell_char(cell_char), .cell_attr(cell_attr),
		.cursor_column_now(cursor_column_now), .cursor_row_now(cursor_row_now)
	);

	tcw_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .done(done),
		.operation(operation), .char_code(char_code), .hex_value(hex_value),
		.read_row(read_row), .read_column(read_column),
		.cell_char(cell_char), .cell_attr(cell_attr),
		.cursor_column_now(cursor_column_now), .cursor_row_now(cursor_row_now),
		.error_count(error_count), .outstanding(outstanding)
	);

	always #CLK_HALF clk = ~clk;

	// present one command word and hold it until the block takes it
	task automatic issue_command(op_t op, logic [7:0] ch, logic [31:0] hv,
			logic [4:0] rr, logic [6:0] rc);
		start <= 1'b1;
		operation <= op;
		char_code <= ch;
		hex_value <= hv;
		read_row <= rr;
		read_column <= rc;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random command word: mostly text output, some reads, rare clears
	task automatic issue_random_command();
		int pick;
		op_t op;
		logic [7:0] ch;
		logic [4:0] rr;
		logic [6:0] rc;
		pick = $urandom_range(0, 999);
		ch = 8'($urandom_range(0, 255));
		rr = 5'($urandom);
		rc = 7'($urandom);
		if (pick < 2) begin
			op = OP_CLEAR;
		end else if (pick < 480) begin
			op = OP_PUT_CHAR;
			if ($urandom_range(0, 4) == 0)
				ch = NEWLINE_CHAR;
		end else if (pick < 680) begin
			op = OP_PUT_HEX;
		end else begin
			op = OP_READ;
			rr = ($urandom_range(0, 11) == 0) ? 5'($urandom_range(25, 31))
				: 5'($urandom_range(0, 24));
			rc = ($urandom_range(0, 11) == 0) ? 7'($urandom_range(80, 127))
				: 7'($urandom_range(0, 79));
		end
		issue_command(op, ch, $urandom, rr, rc);
	endtask

	// stop sending and wait until every result word is back and the block is idle
	task automatic drain_console();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_register(logic [2:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [7:0] attr;
		int sent;
		int burst;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the clearing sweep after reset
		@(posedge clk);
		while (busy)
			@(posedge clk);
		read_register(ATTR_ADDR);

		// directed words at the reset attribute
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd0, 7'd0);
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd31, 7'd127);
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd24, 7'd79);
		issue_command(OP_PUT_CHAR, 8'h00, $urandom, 5'($urandom), 7'($urandom));
		issue_command(OP_PUT_CHAR, 8'hFF, $urandom, 5'($urandom), 7'($urandom));
		issue_command(OP_PUT_CHAR, NEWLINE_CHAR, $urandom, 5'($urandom), 7'($urandom));
		issue_command(OP_PUT_HEX, 8'($urandom), 32'h0000_0000, 5'($urandom), 7'($urandom));
		issue_command(OP_PUT_HEX, 8'($urandom), 32'hFFFF_FFFF, 5'($urandom), 7'($urandom));
		issue_command(OP_PUT_HEX, 8'($urandom), 32'h0123_4567, 5'($urandom), 7'($urandom));
		issue_command(OP_PUT_HEX, 8'($urandom), 32'h89AB_CDEF, 5'($urandom), 7'($urandom));
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd0, 7'd0);
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd0, 7'd1);
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd1, 7'd11);
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd0, 7'd80);
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd25, 7'd0);
		// run past the end of a row to force a wrap
		repeat (7) issue_command(OP_PUT_HEX, 8'($urandom), $urandom, 5'($urandom),
			7'($urandom));
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd2, 7'd79);
		issue_command(OP_CLEAR, 8'($urandom), $urandom, 5'($urandom), 7'($urandom));
		issue_command(OP_READ, 8'($urandom), $urandom, 5'd1, 7'd5);

		// random phases, each under its own attribute
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_console();
			case (phase)
				0: attr = 8'h00;
				1: attr = 8'hFF;
				PHASES - 1: attr = RESET_ATTR;
				default: attr = 8'($urandom_range(0, 255));
			endcase
			write_register(ATTR_ADDR, {24'($urandom), attr});
			read_register(ATTR_ADDR);
			// a write to the unmapped slot must leave the attribute alone
			if (phase == 2) begin
				write_register(SPARE_ADDR, $urandom);
				read_register(ATTR_ADDR);
			end
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
				repeat (burst) begin
					issue_random_command();
					sent++;
				end
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end

		drain_console();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#100_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
